// ===== sv/shps_pkg.sv =====
// Shared constants, types and codes of the segment heat profile sequencer.
package shps_pkg;

   localparam int NUM_WORKPIECES = 5;
   localparam int NUM_SEGMENTS   = 5;
   localparam int TICKS_PER_STEP = 20;

   typedef logic [15:0] word_type;
   typedef logic [7:0]  work_num_type;
   typedef logic [2:0]  rec_addr_type;
   typedef logic [2:0]  seg_now_type;

   localparam word_type POWER_LIMIT_RESET = 16'hFFFF;

   localparam logic ACT_EVAL  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   localparam logic KIND_TIME  = 1'b0;
   localparam logic KIND_POWER = 1'b1;

   typedef struct packed {
      word_type    power_target;
      seg_now_type segment_now;
      logic        is_running;
      logic        finished;
   } result_type;

endpackage

// ===== sv/shps_if.sv =====
// Request and response channel interfaces of the segment heat profile sequencer.
interface shps_req_if;
   logic                     valid;
   logic                     ready;
   logic                     action;
   shps_pkg::word_type       tick_stamp;
   shps_pkg::work_num_type   work_number;
   logic                     enable;
   shps_pkg::rec_addr_type   wr_work;
   shps_pkg::rec_addr_type   wr_segment;
   logic                     wr_kind;
   shps_pkg::word_type       wr_value;

   modport source (
      output valid, action, tick_stamp, work_number, enable,
             wr_work, wr_segment, wr_kind, wr_value,
      input  ready
   );
   modport sink (
      input  valid, action, tick_stamp, work_number, enable,
             wr_work, wr_segment, wr_kind, wr_value,
      output ready
   );
endinterface

interface shps_rsp_if;
   logic                    valid;
   logic                    ready;
   shps_pkg::word_type      power_target;
   shps_pkg::seg_now_type   segment_now;
   logic                    is_running;
   logic                    finished;

   modport source (
      output valid, power_target, segment_now, is_running, finished,
      input  ready
   );
   modport sink (
      input  valid, power_target, segment_now, is_running, finished,
      output ready
   );
endinterface

// ===== sv/segment_heat_profile_sequencer_unit.sv =====
// Segment heat profile sequencer: recipe store, step counter and segment walker.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-----------------------------------------------
//   req_if   | in  | valid / ready      | action tick_stamp work_number enable wr_* fields
//   rsp_if   | out | valid / ready      | power_target segment_now is_running finished
//   csr      | in  | csr_wr_en          | csr_wr_data = power_limit
//
// Write beats and disabled or invalid evaluate beats answer without a recipe read;
// other evaluate beats read k recipe segments (1..NUM_SEGMENTS), one per cycle from the
// store read port. Ready stays low until the result has moved into the output register.
// The tick-to-step conversion is a reciprocal multiply, a back multiply and a correction.
// Reset is synchronous; recipe entries read as zero until written (per-entry valid bits).
// A stalled response holds in the output register; a new beat is taken meanwhile.
module segment_heat_profile_sequencer_unit #(
   parameter int NUM_WORKPIECES = shps_pkg::NUM_WORKPIECES,
   parameter int NUM_SEGMENTS   = shps_pkg::NUM_SEGMENTS,
   parameter int TICKS_PER_STEP = shps_pkg::TICKS_PER_STEP
) (
   input  logic               clock,
   input  logic               reset,
   shps_req_if.sink           req_if,
   shps_rsp_if.source         rsp_if,
   input  logic               csr_wr_en,
   input  shps_pkg::word_type csr_wr_data
);

   localparam int Depth    = NUM_WORKPIECES * NUM_SEGMENTS;
   localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int WorkW    = (NUM_WORKPIECES > 1) ? $clog2(NUM_WORKPIECES) : 1;
   localparam int SegW     = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
   localparam int DivShift = 24;
   localparam int unsigned Recip = (32'd1 << DivShift) / TICKS_PER_STEP;
   localparam int RecipW   = $clog2(Recip + 1);
   localparam int ProdW    = DivShift + 16;

   localparam logic [RecipW-1:0] RecipVec = RecipW'(Recip);
   localparam shps_pkg::word_type TpsVec  = 16'(TICKS_PER_STEP);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_DIV  = 7'b0000010,
      S_MUL  = 7'b0000100,
      S_BACK = 7'b0001000,
      S_ACC  = 7'b0010000,
      S_UPD  = 7'b0100000,
      S_CHK  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      out_pend_ff, out_pend_in;

   logic                run_ff, run_in;
   logic [SegW-1:0]     seg_ofs_ff, seg_ofs_in;
   shps_pkg::word_type  elapsed_ff, elapsed_in;
   shps_pkg::word_type  last_tick_ff, last_tick_in;
   shps_pkg::word_type  limit_ff;

   shps_pkg::word_type  now_ff, now_in;
   logic [WorkW-1:0]    work_ofs_ff, work_ofs_in;
   shps_pkg::word_type  diff_ff, diff_in;
   logic [ProdW-1:0]    prod_ff;
   shps_pkg::word_type  q0_ff;
   shps_pkg::word_type  qt_ff;
   shps_pkg::word_type  steps_ff, steps_in;
   shps_pkg::word_type  stt_ff, stt_in;
   logic [AddrW-1:0]    addr_ff, raddr;
   shps_pkg::result_type res_ff, res_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   shps_pkg::result_type rsp_data_ff;
   logic                 out_load;

   shps_pkg::word_type  time_mem [Depth];
   shps_pkg::word_type  pwr_mem  [Depth];
   logic [Depth-1:0]    time_vld_ff, pwr_vld_ff;
   shps_pkg::word_type  time_q_ff, pwr_q_ff;
   logic                time_qv_ff, pwr_qv_ff;

   logic                accept;
   logic                wr_ok, we_time, we_pwr;
   logic [AddrW-1:0]    waddr;
   logic                work_ok;
   shps_pkg::word_type  rd_time, rd_pwr, rem;
   logic [16:0]         sum;
   logic                skip;

   assign accept       = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == S_IDLE) && !out_pend_ff;

   assign wr_ok = (int'(req_if.wr_work) >= 1) && (int'(req_if.wr_work) <= NUM_WORKPIECES) &&
                  (int'(req_if.wr_segment) >= 1) && (int'(req_if.wr_segment) <= NUM_SEGMENTS);
   assign waddr = AddrW'((int'(req_if.wr_work) - 1) * NUM_SEGMENTS +
                         int'(req_if.wr_segment) - 1);
   assign we_time = accept && (req_if.action == shps_pkg::ACT_WRITE) && wr_ok &&
                    (req_if.wr_kind == shps_pkg::KIND_TIME);
   assign we_pwr  = accept && (req_if.action == shps_pkg::ACT_WRITE) && wr_ok &&
                    (req_if.wr_kind == shps_pkg::KIND_POWER);

   assign work_ok = (req_if.work_number != '0) &&
                    (int'(req_if.work_number) <= NUM_WORKPIECES);

   assign rd_time = time_qv_ff ? time_q_ff : '0;
   assign rd_pwr  = pwr_qv_ff ? pwr_q_ff : '0;
   assign skip    = (rd_time == '0) || (elapsed_ff >= rd_time);
   assign rem     = diff_ff - qt_ff;
   assign sum     = {1'b0, elapsed_ff} + {1'b0, steps_ff};

   always_comb begin
      unique case (state_ff)
         S_UPD:   raddr = AddrW'(work_ofs_ff) * AddrW'(NUM_SEGMENTS) + AddrW'(seg_ofs_ff);
         S_CHK:   raddr = addr_ff + AddrW'(1);
         default: raddr = addr_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      out_pend_in  = out_pend_ff;
      run_in       = run_ff;
      seg_ofs_in   = seg_ofs_ff;
      elapsed_in   = elapsed_ff;
      last_tick_in = last_tick_ff;
      now_in       = now_ff;
      work_ofs_in  = work_ofs_ff;
      diff_in      = diff_ff;
      steps_in     = steps_ff;
      stt_in       = stt_ff;
      res_in       = res_ff;
      out_load     = 1'b0;

      if (out_pend_ff && (!rsp_valid_ff || rsp_if.ready)) begin
         out_load    = 1'b1;
         out_pend_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               now_in      = req_if.tick_stamp;
               work_ofs_in = WorkW'(req_if.work_number - 8'd1);
               res_in      = '0;
               if (req_if.action == shps_pkg::ACT_WRITE) begin
                  res_in.segment_now = run_ff ? shps_pkg::seg_now_type'(seg_ofs_ff) + 3'd1
                                              : '0;
                  res_in.is_running  = run_ff;
                  out_pend_in        = 1'b1;
               end else if (!req_if.enable || !work_ok) begin
                  run_in       = 1'b0;
                  seg_ofs_in   = '0;
                  elapsed_in   = '0;
                  last_tick_in = req_if.tick_stamp;
                  out_pend_in  = 1'b1;
               end else begin
                  diff_in = req_if.tick_stamp - last_tick_ff;
                  if (!run_ff) begin
                     run_in       = 1'b1;
                     seg_ofs_in   = '0;
                     elapsed_in   = '0;
                     last_tick_in = req_if.tick_stamp;
                  end
                  state_in = S_DIV;
               end
            end
         end
         S_DIV:  state_in = S_MUL;
         S_MUL:  state_in = S_BACK;
         S_BACK: state_in = S_ACC;
         S_ACC: begin
            if (rem >= TpsVec) begin
               steps_in = q0_ff + 16'd1;
               stt_in   = qt_ff + TpsVec;
            end else begin
               steps_in = q0_ff;
               stt_in   = qt_ff;
            end
            state_in = S_UPD;
         end
         S_UPD: begin
            elapsed_in   = sum[16] ? 16'hFFFF : sum[15:0];
            last_tick_in = last_tick_ff + stt_ff;
            state_in     = S_CHK;
         end
         S_CHK: begin
            res_in = '0;
            if (skip) begin
               elapsed_in   = '0;
               last_tick_in = now_ff;
               if (int'(seg_ofs_ff) == NUM_SEGMENTS - 1) begin
                  run_in          = 1'b0;
                  seg_ofs_in      = '0;
                  res_in.finished = 1'b1;
                  out_pend_in     = 1'b1;
                  state_in        = S_IDLE;
               end else begin
                  seg_ofs_in = seg_ofs_ff + SegW'(1);
               end
            end else begin
               res_in.power_target = (rd_pwr > limit_ff) ? limit_ff : rd_pwr;
               res_in.segment_now  = shps_pkg::seg_now_type'(seg_ofs_ff) + 3'd1;
               res_in.is_running   = 1'b1;
               out_pend_in         = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_pend_ff  <= 1'b0;
         run_ff       <= 1'b0;
         seg_ofs_ff   <= '0;
         elapsed_ff   <= '0;
         last_tick_ff <= '0;
         limit_ff     <= shps_pkg::POWER_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         time_vld_ff  <= '0;
         pwr_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         out_pend_ff  <= out_pend_in;
         run_ff       <= run_in;
         seg_ofs_ff   <= seg_ofs_in;
         elapsed_ff   <= elapsed_in;
         last_tick_ff <= last_tick_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (we_time) begin
            time_vld_ff[waddr] <= 1'b1;
         end
         if (we_pwr) begin
            pwr_vld_ff[waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      work_ofs_ff <= work_ofs_in;
      diff_ff     <= diff_in;
      prod_ff     <= ProdW'(diff_ff) * ProdW'(RecipVec);
      q0_ff       <= prod_ff[DivShift +: 16];
      qt_ff       <= shps_pkg::word_type'(q0_ff * TpsVec);
      steps_ff    <= steps_in;
      stt_ff      <= stt_in;
      addr_ff     <= raddr;
      res_ff      <= res_in;
      if (out_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   // recipe store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we_time) begin
         time_mem[waddr] <= req_if.wr_value;
      end
      if (we_pwr) begin
         pwr_mem[waddr] <= req_if.wr_value;
      end
      time_q_ff  <= time_mem[raddr];
      pwr_q_ff   <= pwr_mem[raddr];
      time_qv_ff <= time_vld_ff[raddr];
      pwr_qv_ff  <= pwr_vld_ff[raddr];
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.power_target = rsp_data_ff.power_target;
   assign rsp_if.segment_now  = rsp_data_ff.segment_now;
   assign rsp_if.is_running   = rsp_data_ff.is_running;
   assign rsp_if.finished     = rsp_data_ff.finished;

endmodule

// ===== sv/shps_checker.sv =====
// Port-level assertions for the segment heat profile sequencer, bound to the top level.
module shps_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input shps_pkg::word_type power_target,
   input logic [2:0]         segment_now,
   input logic               is_running,
   input logic               finished
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous beat still in work");

   a_finished_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && finished |-> !is_running && segment_now == 3'd0 && power_target == '0)
      else $error("finished beat carries run state");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !is_running |-> segment_now == 3'd0 && power_target == '0)
      else $error("idle beat carries segment or power");

   a_run_segment: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_running |-> segment_now != 3'd0 && !finished)
      else $error("running beat without segment");

endmodule

bind segment_heat_profile_sequencer_unit shps_checker u_shps_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .power_target (rsp_if.power_target),
   .segment_now  (rsp_if.segment_now),
   .is_running   (rsp_if.is_running),
   .finished     (rsp_if.finished)
);

// ===== sim/tb.sv =====
// Testbench for segment_heat_profile_sequencer_unit: directed table, random recipes, predictor.
`timescale 1ns / 1ps

module tb;

   localparam int NUM_WORKPIECES = shps_pkg::NUM_WORKPIECES;
   localparam int NUM_SEGMENTS   = shps_pkg::NUM_SEGMENTS;
   localparam int TICKS_PER_STEP = shps_pkg::TICKS_PER_STEP;

   typedef shps_pkg::word_type     word_type;
   typedef shps_pkg::work_num_type work_num_type;
   typedef shps_pkg::rec_addr_type rec_addr_type;
   typedef shps_pkg::seg_now_type  seg_now_type;
   typedef shps_pkg::result_type   result_type;

   localparam word_type POWER_LIMIT_RESET = shps_pkg::POWER_LIMIT_RESET;
   localparam logic     ACT_EVAL          = shps_pkg::ACT_EVAL;
   localparam logic     ACT_WRITE         = shps_pkg::ACT_WRITE;
   localparam logic     KIND_TIME         = shps_pkg::KIND_TIME;
   localparam logic     KIND_POWER        = shps_pkg::KIND_POWER;

   localparam int STORE_DEPTH   = NUM_WORKPIECES * NUM_SEGMENTS;
   localparam int ITEM_TARGET   = 1500;
   localparam int CFG_SPACING   = 300;
   localparam int QUIET_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 24;
   localparam int DIRECTED_ROWS = 25;

   typedef struct {
      logic         action;
      word_type     tick_stamp;
      work_num_type work_number;
      logic         enable;
      rec_addr_type wr_work;
      rec_addr_type wr_segment;
      logic         wr_kind;
      word_type     wr_value;
   } profile_cmd_type;

   typedef struct {
      profile_cmd_type cmd;
      bit              known;
      result_type      fixed;
   } dir_row_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   word_type   csr_wr_data;

   shps_req_if req_bus ();
   shps_rsp_if rsp_bus ();

   segment_heat_profile_sequencer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor copy of the block
   word_type   rec_duration [STORE_DEPTH] = '{default: '0};
   word_type   rec_power    [STORE_DEPTH] = '{default: '0};
   bit         seq_running   = 1'b0;
   int         seq_segment   = 0;
   int         seq_elapsed   = 0;
   word_type   seq_last_tick = '0;
   word_type   limit_shadow  = POWER_LIMIT_RESET;

   result_type expected_profile_q [$];
   int         error_count  = 0;
   int         items_sent   = 0;
   int         stall_left   = 0;
   int         quiet_cycles = 0;
   bit         burst_mode   = 1'b0;

   //   action      tick  work en ww ws kind         value   known  power  seg run fin
   dir_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{ACT_EVAL,      0,   1, 0, 0, 0, KIND_TIME,      0}, 1, '{0, 0, 0, 0}},
      '{'{ACT_EVAL,      5,   0, 1, 0, 0, KIND_TIME,      0}, 1, '{0, 0, 0, 0}},
      '{'{ACT_EVAL,     10, 255, 1, 0, 0, KIND_TIME,      0}, 1, '{0, 0, 0, 0}},
      '{'{ACT_EVAL,     15,   6, 1, 0, 0, KIND_TIME,      0}, 1, '{0, 0, 0, 0}},
      '{'{ACT_EVAL,     20,   5, 1, 0, 0, KIND_TIME,      0}, 1, '{0, 0, 0, 1}},
      '{'{ACT_WRITE,     0,   0, 0, 1, 1, KIND_TIME,      2}, 1, '{0, 0, 0, 0}},
      '{'{ACT_WRITE,     0,   0, 0, 1, 1, KIND_POWER, 65535}, 1, '{0, 0, 0, 0}},
      '{'{ACT_WRITE,     0,   0, 0, 1, 2, KIND_TIME,  65535}, 1, '{0, 0, 0, 0}},
      '{'{ACT_WRITE,     0,   0, 0, 1, 2, KIND_POWER,  1000}, 1, '{0, 0, 0, 0}},
      '{'{ACT_WRITE,     0,   0, 0, 1, 5, KIND_TIME,      1}, 1, '{0, 0, 0, 0}},
      '{'{ACT_WRITE,     0,   0, 0, 1, 5, KIND_POWER,    77}, 1, '{0, 0, 0, 0}},
      '{'{ACT_WRITE,     0,   0, 0, 0, 1, KIND_TIME,      5}, 1, '{0, 0, 0, 0}},
      '{'{ACT_WRITE,     0,   0, 0, 7, 7, KIND_POWER,     9}, 1, '{0, 0, 0, 0}},
      '{'{ACT_WRITE,     0,   0, 0, 1, 0, KIND_TIME,      3}, 1, '{0, 0, 0, 0}},
      '{'{ACT_WRITE,     0,   0, 0, 1, 6, KIND_POWER,     4}, 1, '{0, 0, 0, 0}},
      '{'{ACT_EVAL,     30,   1, 1, 0, 0, KIND_TIME,      0}, 0, '{0, 0, 0, 0}},
      '{'{ACT_EVAL,     70,   1, 1, 0, 0, KIND_TIME,      0}, 0, '{0, 0, 0, 0}},
      '{'{ACT_WRITE,     0,   1, 1, 1, 3, KIND_TIME,      0}, 1, '{0, 2, 1, 0}},
      '{'{ACT_EVAL,  65535,   1, 1, 0, 0, KIND_TIME,      0}, 0, '{0, 0, 0, 0}},
      '{'{ACT_EVAL,      4,   1, 1, 0, 0, KIND_TIME,      0}, 0, '{0, 0, 0, 0}},
      '{'{ACT_EVAL,     50,   2, 1, 0, 0, KIND_TIME,      0}, 0, '{0, 0, 0, 0}},
      '{'{ACT_EVAL,     60,   1, 1, 0, 0, KIND_TIME,      0}, 0, '{0, 0, 0, 0}},
      '{'{ACT_EVAL,     60,   1, 0, 0, 0, KIND_TIME,      0}, 1, '{0, 0, 0, 0}},
      '{'{ACT_WRITE,     0,   0, 0, 5, 5, KIND_TIME,  65535}, 1, '{0, 0, 0, 0}},
      '{'{ACT_WRITE,     0,   0, 0, 5, 5, KIND_POWER, 65535}, 1, '{0, 0, 0, 0}}
   };

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic profile_cmd_type eval_cmd(word_type now, int work, bit en);
      profile_cmd_type c;
      c = '{ACT_EVAL, now, work_num_type'(work), en, '0, '0, KIND_TIME, '0};
      return c;
   endfunction

   function automatic profile_cmd_type write_cmd(int wk, int sg, logic kind, word_type val);
      profile_cmd_type c;
      c = '{ACT_WRITE, '0, '0, 1'b0, rec_addr_type'(wk), rec_addr_type'(sg), kind, val};
      return c;
   endfunction

   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic void clear_sequencer(word_type now);
      seq_running   = 1'b0;
      seq_segment   = 0;
      seq_elapsed   = 0;
      seq_last_tick = now;
   endfunction

   function automatic result_type predict_profile(profile_cmd_type cmd);
      result_type r;
      word_type   diff;
      word_type   dur;
      word_type   pw;
      int         steps;
      int         sum;
      int         base;
      r = '0;
      if (cmd.action == ACT_WRITE) begin
         if (cmd.wr_work >= 1 && cmd.wr_work <= NUM_WORKPIECES &&
             cmd.wr_segment >= 1 && cmd.wr_segment <= NUM_SEGMENTS) begin
            base = (int'(cmd.wr_work) - 1) * NUM_SEGMENTS + int'(cmd.wr_segment) - 1;
            if (cmd.wr_kind == KIND_TIME) rec_duration[base] = cmd.wr_value;
            else rec_power[base] = cmd.wr_value;
         end
         r.segment_now = seq_running ? seg_now_type'(seq_segment) : '0;
         r.is_running  = seq_running;
         return r;
      end
      if (!cmd.enable) begin
         clear_sequencer(cmd.tick_stamp);
         return r;
      end
      diff = cmd.tick_stamp - seq_last_tick;
      if (cmd.work_number == 0 || cmd.work_number > NUM_WORKPIECES) begin
         clear_sequencer(cmd.tick_stamp);
         return r;
      end
      if (!seq_running) begin
         seq_running   = 1'b1;
         seq_segment   = 1;
         seq_elapsed   = 0;
         seq_last_tick = cmd.tick_stamp;
      end
      steps = int'(diff) / TICKS_PER_STEP;
      sum = seq_elapsed + steps;
      seq_elapsed = (sum > 65535) ? 65535 : sum;
      seq_last_tick = seq_last_tick + word_type'(steps * TICKS_PER_STEP);
      base = (int'(cmd.work_number) - 1) * NUM_SEGMENTS;
      while (seq_segment <= NUM_SEGMENTS) begin
         dur = rec_duration[base + seq_segment - 1];
         if (dur != 0 && seq_elapsed < dur) break;
         seq_segment++;
         seq_elapsed   = 0;
         seq_last_tick = cmd.tick_stamp;
      end
      if (seq_segment > NUM_SEGMENTS) begin
         clear_sequencer(cmd.tick_stamp);
         r.finished = 1'b1;
         return r;
      end
      pw = rec_power[base + seq_segment - 1];
      if (pw > limit_shadow) pw = limit_shadow;
      r.power_target = pw;
      r.segment_now  = seg_now_type'(seq_segment);
      r.is_running   = 1'b1;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 100) $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   task automatic send_item(input profile_cmd_type cmd, input bit known,
                            input result_type fixed);
      int         gap;
      result_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= cmd.action;
      req_bus.tick_stamp  <= cmd.tick_stamp;
      req_bus.work_number <= cmd.work_number;
      req_bus.enable      <= cmd.enable;
      req_bus.wr_work     <= cmd.wr_work;
      req_bus.wr_segment  <= cmd.wr_segment;
      req_bus.wr_kind     <= cmd.wr_kind;
      req_bus.wr_value    <= cmd.wr_value;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      predicted = predict_profile(cmd);
      expected_profile_q.push_back(known ? fixed : predicted);
      items_sent++;
   endtask

   task automatic check_profile_beat();
      result_type want;
      if (expected_profile_q.size() == 0) begin
         report_mismatch($sformatf("unexpected beat: power %0d seg %0d run %0d fin %0d",
            rsp_bus.power_target, rsp_bus.segment_now, rsp_bus.is_running, rsp_bus.finished));
         return;
      end
      want = expected_profile_q.pop_front();
      if (rsp_bus.power_target !== want.power_target)
         report_mismatch($sformatf("power_target got %0d expected %0d",
            rsp_bus.power_target, want.power_target));
      if (rsp_bus.segment_now !== want.segment_now)
         report_mismatch($sformatf("segment_now got %0d expected %0d",
            rsp_bus.segment_now, want.segment_now));
      if (rsp_bus.is_running !== want.is_running)
         report_mismatch($sformatf("is_running got %0d expected %0d",
            rsp_bus.is_running, want.is_running));
      if (rsp_bus.finished !== want.finished)
         report_mismatch($sformatf("finished got %0d expected %0d",
            rsp_bus.finished, want.finished));
   endtask

   always @(posedge clock) begin : rsp_side
      int g;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_profile_beat();
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= stall_left - 1;
         end else begin
            g = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            rsp_bus.ready <= (g == 0);
            stall_left    <= (g > 0) ? g - 1 : 0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("segment_heat_profile_sequencer_unit test failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      profile_cmd_type cmd;
      word_type        tick_now;
      word_type        lim;
      word_type        t;
      int              k;
      int              n;
      int              r;
      int              s;
      int              w;
      int              phase;
      int              next_cfg_at;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      rsp_bus.ready       = 1'b0;
      req_bus.valid       = 1'b0;
      req_bus.action      = ACT_EVAL;
      req_bus.tick_stamp  = '0;
      req_bus.work_number = '0;
      req_bus.enable      = 1'b0;
      req_bus.wr_work     = '0;
      req_bus.wr_segment  = '0;
      req_bus.wr_kind     = KIND_TIME;
      req_bus.wr_value    = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < DIRECTED_ROWS; k++)
         send_item(directed_rows[k].cmd, directed_rows[k].known, directed_rows[k].fixed);

      tick_now    = 16'd100;
      phase       = 0;
      next_cfg_at = items_sent;
      while (items_sent < DIRECTED_ROWS + ITEM_TARGET) begin
         if (items_sent >= next_cfg_at) begin
            case (phase)
               0: lim = '0;
               1: lim = 16'hFFFF;
               2: lim = word_type'($urandom_range(0, 3000));
               default: lim = word_type'($urandom_range(0, 65535));
            endcase
            req_bus.valid <= 1'b0;
            while (expected_profile_q.size() != 0) @(posedge clock);
            csr_wr_en   <= 1'b1;
            csr_wr_data <= lim;
            @(posedge clock);
            csr_wr_en    <= 1'b0;
            limit_shadow = lim;
            phase++;
            next_cfg_at = items_sent + CFG_SPACING;
         end
         burst_mode = ($urandom_range(0, 7) == 0);
         r = $urandom_range(0, 99);
         if (r < 70) begin
            // program a recipe, then walk it with a ticking clock
            w = $urandom_range(1, NUM_WORKPIECES);
            for (s = 1; s <= NUM_SEGMENTS; s++) begin
               if ($urandom_range(0, 9) != 0) begin
                  r = $urandom_range(0, 99);
                  if (r < 15) t = '0;
                  else if (r < 85) t = word_type'($urandom_range(1, 4));
                  else if (r < 95) t = word_type'($urandom_range(5, 20));
                  else t = word_type'($urandom_range(0, 65535));
                  send_item(write_cmd(w, s, KIND_TIME, t), 1'b0, '0);
                  send_item(write_cmd(w, s, KIND_POWER, word_type'($urandom_range(0, 65535))),
                     1'b0, '0);
               end
            end
            n = $urandom_range(4, 16);
            for (k = 0; k < n; k++) begin
               r = $urandom_range(0, 99);
               if (r < 70) tick_now += word_type'($urandom_range(0, 40));
               else if (r < 90) tick_now += word_type'($urandom_range(41, 400));
               else tick_now += word_type'($urandom_range(0, 65535));
               r = $urandom_range(0, 99);
               if (r < 8) begin
                  send_item(eval_cmd(tick_now, $urandom_range(1, NUM_WORKPIECES), 1'b1),
                     1'b0, '0);
               end else if (r < 12) begin
                  send_item(eval_cmd(tick_now, w, 1'b0), 1'b0, '0);
               end else if (r < 16) begin
                  send_item(eval_cmd(tick_now,
                     $urandom_range(0, 1) ? 0 : $urandom_range(NUM_WORKPIECES + 1, 255), 1'b1),
                     1'b0, '0);
               end else begin
                  if (r < 20)
                     send_item(write_cmd($urandom_range(0, 7), $urandom_range(0, 7),
                        logic'($urandom_range(0, 1)), word_type'($urandom_range(0, 65535))),
                        1'b0, '0);
                  send_item(eval_cmd(tick_now, w, 1'b1), 1'b0, '0);
               end
            end
         end else if (r < 76) begin
            // very long first segment: elapsed count runs into saturation
            w = $urandom_range(1, NUM_WORKPIECES);
            send_item(write_cmd(w, 1, KIND_TIME, 16'hFFFF - word_type'($urandom_range(0, 1))),
               1'b0, '0);
            send_item(write_cmd(w, 1, KIND_POWER, word_type'($urandom_range(0, 65535))),
               1'b0, '0);
            send_item(eval_cmd(tick_now, w, 1'b0), 1'b0, '0);
            tick_now += word_type'($urandom_range(0, 19));
            send_item(eval_cmd(tick_now, w, 1'b1), 1'b0, '0);
            for (k = 0; k < 23; k++) begin
               tick_now += word_type'($urandom_range(65496, 65516));
               send_item(eval_cmd(tick_now, w, 1'b1), 1'b0, '0);
            end
         end else begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
               cmd.action      = logic'($urandom_range(0, 1));
               cmd.tick_stamp  = word_type'($urandom_range(0, 65535));
               cmd.work_number = work_num_type'($urandom_range(0, 255));
               cmd.enable      = logic'($urandom_range(0, 1));
               cmd.wr_work     = rec_addr_type'($urandom_range(0, 7));
               cmd.wr_segment  = rec_addr_type'($urandom_range(0, 7));
               cmd.wr_kind     = logic'($urandom_range(0, 1));
               cmd.wr_value    = word_type'($urandom_range(0, 65535));
               send_item(cmd, 1'b0, '0);
            end
         end
      end

      req_bus.valid <= 1'b0;
      while (expected_profile_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("segment_heat_profile_sequencer_unit test passed");
      end else begin
         $display("segment_heat_profile_sequencer_unit test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/shps_pkg.sv
sv/shps_if.sv
sv/segment_heat_profile_sequencer_unit.sv
sv/shps_checker.sv
sim/tb.sv
